/* sv/swm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window maximum
// Word type, most negative sample and the control group that runs the cells.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WORD_W         = 32;
	localparam int LEN_W          = 5;
	localparam int WINDOW_MAX_DEF = 16;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [LEN_W-1:0]         len_t;

	localparam word_t MOST_NEG = 32'sh8000_0000;

	// control from the sequencer to the cell row and the result register
	typedef struct packed {
		logic shift;   // take a new item into the row
		logic clear;   // the item starts a sequence: flush older samples
		logic load;    // capture the finished maximum
	} ctl_t;

endpackage

/* sv/sliding_window_max_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_core: running maximum over a sliding window of samples
// Signed 32-bit samples in, windowed maximum out, sequences framed by marks.
// ----------------------------------------------------------------------------
// Samples enter a row of WINDOW_MAX cells, newest in cell 0; a first mark
// flushes the older samples. Each cell keeps a partial maximum that it hands
// to its neighbour every cycle, so the maximum of the newest k samples
// settles in cell k-1 (k is the window length, 1 to WINDOW_MAX). An item
// that yields a result holds the input off until its maximum is loaded
// into the output register; a one-sample sequence is read from cell 0. An
// item that yields none does not hold the input off. The settling of the
// cell row sets the length of the scan; a scan cannot finish while an
// earlier result is still held by out_stall, and that wait adds on. The
// result sits in an output register, so the next item is taken while it
// waits. in_stall is high during the scan.
// window_len is written through the cfg channel, which is always ready;
// write it only while the block is idle. Lengths of zero count as one,
// lengths above WINDOW_MAX as WINDOW_MAX.
// ----------------------------------------------------------------------------
module sliding_window_max_core #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	// configuration
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  swm_pkg::len_t  window_len,
	// input items
	input  logic           in_valid,
	output logic           in_stall,
	input  swm_pkg::word_t sample,
	input  logic           first,
	input  logic           last,
	// result items
	output logic           out_valid,
	input  logic           out_stall,
	output swm_pkg::word_t window_max,
	output logic           end_of_sequence
);
	import swm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	ctl_t             ctl;
	logic [IDX_W-1:0] sel;
	word_t            data_w [WINDOW_MAX];
	word_t            acc_w  [WINDOW_MAX];
	word_t            window_max_q;

	assign cfg_ready = 1'b1;

	// sequencer: length register, fill count, scan timing, result handshake
	swm_ctrl #(
		.WINDOW_MAX (WINDOW_MAX),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_valid && cfg_ready),
		.cfg_len         (window_len),
		.in_valid        (in_valid),
		.first           (first),
		.last            (last),
		.in_stall        (in_stall),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.end_of_sequence (end_of_sequence),
		.ctl             (ctl),
		.sel             (sel)
	);

	// the cell row: cell 0 always takes the new sample, the rest flush on first
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			swm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (ctl.shift),
				.clear    (1'b0),
				.data_in  (sample),
				.acc_in   (MOST_NEG),
				.data_out (data_w[i]),
				.acc_out  (acc_w[i])
			);
		end else begin : g_body
			swm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (ctl.shift),
				.clear    (ctl.clear),
				.data_in  (data_w[i-1]),
				.acc_in   (acc_w[i-1]),
				.data_out (data_w[i]),
				.acc_out  (acc_w[i])
			);
		end
	end

	// hold the settled maximum until the result is taken
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			window_max_q <= acc_w[sel];
		end
	end

	assign window_max = window_max_q;

endmodule

/* sv/swm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell: one cell of the window row
// Holds one stored sample and a partial maximum handed on to its neighbour.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          clear,
	input  swm_pkg::word_t data_in,
	input  swm_pkg::word_t acc_in,
	output swm_pkg::word_t data_out,
	output swm_pkg::word_t acc_out
);
	import swm_pkg::*;

	word_t data_q;
	word_t acc_q;

	// stored sample: advance from the neighbour, drop on a new sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= MOST_NEG;
		end else if (shift) begin
			data_q <= clear ? MOST_NEG : data_in;
		end
	end

	// partial maximum of this cell and all cells before it
	always_ff @(posedge clk) begin
		acc_q <= (data_q > acc_in) ? data_q : acc_in;
	end

	assign data_out = data_q;
	assign acc_out  = acc_q;

endmodule

/* sv/swm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding window maximum
// Window length register, fill count, scan counter and result handshake.
// ----------------------------------------------------------------------------
module swm_ctrl #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
	parameter int CNT_W      = $clog2(WINDOW_MAX + 1),
	parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  swm_pkg::len_t      cfg_len,
	input  logic               in_valid,
	input  logic               first,
	input  logic               last,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               end_of_sequence,
	output swm_pkg::ctl_t      ctl,
	output logic [IDX_W-1:0]   sel
);
	import swm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t           state_q;
	len_t             len_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] tgt_q;
	logic             out_valid_q;
	logic             eos_q;
	logic             res_eos_q;

	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] fill_new;
	logic             accept;
	logic             single;
	logic             produce;
	logic             done;

	always_comb begin
		if (len_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (int'(len_q) > WINDOW_MAX) begin
			k_eff = CNT_W'(WINDOW_MAX);
		end else begin
			k_eff = CNT_W'(len_q);
		end
	end

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign fill_new = first ? CNT_W'(1)
		: ((fill_q == CNT_W'(WINDOW_MAX)) ? fill_q : fill_q + 1'b1);
	assign single   = (fill_new == CNT_W'(1)) && last;
	assign produce  = single || (fill_new >= k_eff);
	assign done     = (state_q == ST_SCAN) && (cnt_q == tgt_q)
		&& (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= len_t'(1);
		end else if (cfg_write) begin
			len_q <= cfg_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			tgt_q       <= CNT_W'(1);
			out_valid_q <= 1'b0;
			eos_q       <= 1'b0;
			res_eos_q   <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_new;
				cnt_q  <= '0;
				tgt_q  <= single ? CNT_W'(1) : k_eff;
				eos_q  <= last;
			end else if (state_q == ST_SCAN && cnt_q != tgt_q) begin
				cnt_q <= cnt_q + 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && produce) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done) begin
				out_valid_q <= 1'b1;
				res_eos_q   <= eos_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign end_of_sequence = res_eos_q;
	assign ctl.shift       = accept;
	assign ctl.clear       = first;
	assign ctl.load        = done;
	assign sel             = IDX_W'(tgt_q - 1'b1);

endmodule

/* sv/swm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker: port-level checks of the sliding window maximum
// Watches the top level's ports over time; attached by bind.
// ----------------------------------------------------------------------------
module swm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input swm_pkg::len_t  window_len,
	input logic           in_valid,
	input logic           in_stall,
	input swm_pkg::word_t sample,
	input logic           first,
	input logic           last,
	input logic           out_valid,
	input logic           out_stall,
	input swm_pkg::word_t window_max,
	input logic           end_of_sequence
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_max)
			&& $stable(end_of_sequence))
		else $error("result changed while stalled");

	// a new result only follows a scan, during which input is held off
	a_rise_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a scan");

	// a one-sample sequence starts a scan
	a_single_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && first && last |=> in_stall)
		else $error("one-sample sequence did not start a scan");

	// a one-sample sequence passes straight through when no result is waiting
	a_single_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && first && last && !out_valid |-> ##3
			(out_valid && window_max == $past(sample, 3) && end_of_sequence))
		else $error("one-sample sequence not passed through");

endmodule

bind sliding_window_max_core swm_checker u_swm_checker (.*);

/* test/tb_sliding_window_max_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_max_core: self-checking bench for the sliding window max
// Drives framed sample sequences under random gaps and back-pressure, keeps
// its own model of the window and compares every result item in order.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_core;
	import swm_pkg::*;

	localparam int WINDOW_DEPTH = WINDOW_MAX_DEF;
	// settle time after draining; it outlasts the slowest item, one with the full window
	localparam int SETTLE_CYCLES = 3 * WINDOW_DEPTH + 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 550;

	typedef struct packed {
		word_t max;
		logic  eos;
	} max_result_t;

	// ports of the block; the inputs are known from time zero
	logic  clk             = 1'b0;
	logic  arst_n          = 1'b0;
	logic  cfg_valid       = 1'b0;
	logic  cfg_ready;
	len_t  window_len      = '0;
	logic  in_valid        = 1'b0;
	logic  in_stall;
	word_t sample          = '0;
	logic  first           = 1'b0;
	logic  last            = 1'b0;
	logic  out_valid;
	logic  out_stall       = 1'b0;
	word_t window_max;
	logic  end_of_sequence;

	// model of the window: newest sample in entry 0
	word_t       sample_hist [WINDOW_DEPTH];
	int unsigned fill_level;
	len_t        len_setting;

	max_result_t expected_maxima [$];

	int   mismatches     = 0;
	int   cycle_count    = 0;
	int   send_idle_pct  = 0;
	int   recv_idle_pct  = 0;
	logic quiet_stretch  = 1'b0;

	sliding_window_max_core #(
		.WINDOW_MAX(WINDOW_DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.window_len     (window_len),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.first          (first),
		.last           (last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_max     (window_max),
		.end_of_sequence(end_of_sequence)
	);

	always #5 clk = ~clk;

	// Count cycles, drive receiver back-pressure and guard against a hang.
	// Periodically pick whether both sides run flat out for a while, so
	// that stretches with no idling turn up inside each phase too.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 128 == 0)
			quiet_stretch <= ($urandom_range(0, 3) == 0);
		out_stall <= !quiet_stretch && (recv_idle_pct != 0) &&
			($urandom_range(0, 99) < recv_idle_pct);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sliding_window_max_core NOT OK");
			$finish;
		end
	end

	// Compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin : check_results
		max_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_maxima.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: window_max=%0d end_of_sequence=%0b",
						window_max, end_of_sequence);
				mismatches++;
			end else begin
				want = expected_maxima.pop_front();
				if (want.max !== window_max || want.eos !== end_of_sequence) begin
					if (mismatches < 10)
						$display("mismatch: expected max=%0d eos=%0b, got max=%0d eos=%0b",
							want.max, want.eos, window_max, end_of_sequence);
					mismatches++;
				end
			end
		end
	end

	// Clear the model window to the most negative value, as at reset or on a
	// first mark.
	function automatic void flush_window();
		foreach (sample_hist[i])
			sample_hist[i] = MOST_NEG;
		fill_level = 0;
	endfunction

	// Advance the model by one accepted item and queue the result it causes.
	function automatic void track_window_max(input word_t s, input logic f, input logic l);
		int          k;
		word_t       best;
		max_result_t res;
		// zero counts as one, anything past the store depth saturates
		k = int'(len_setting);
		if (k == 0)
			k = 1;
		if (k > WINDOW_DEPTH)
			k = WINDOW_DEPTH;
		if (f)
			flush_window();
		for (int i = WINDOW_DEPTH - 1; i > 0; i--)
			sample_hist[i] = sample_hist[i - 1];
		sample_hist[0] = s;
		if (fill_level < WINDOW_DEPTH)
			fill_level++;
		res.eos = l;
		if (fill_level == 1 && l) begin
			// a one-sample sequence passes straight through
			res.max = s;
			expected_maxima = {expected_maxima, res};
		end else if (fill_level >= k) begin
			best = sample_hist[0];
			for (int i = 1; i < k; i++)
				if (sample_hist[i] > best)
					best = sample_hist[i];
			res.max = best;
			expected_maxima = {expected_maxima, res};
		end
	endfunction

	// Present one item and hold it until the block takes it. Valid stays high
	// on return so that back-to-back items need no second assignment.
	task automatic send_sample(input word_t s, input logic f, input logic l);
		if (!quiet_stretch && send_idle_pct != 0 &&
				$urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample   <= s;
		first    <= f;
		last     <= l;
		do
			@(posedge clk);
		while (in_stall);
		track_window_max(s, f, l);
	endtask

	// Drop valid, wait for every outstanding result, then wait out the settle
	// time so that a stray result would still show.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_maxima.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window length once the block has gone idle.
	task automatic write_window_len(input len_t v);
		drain_results();
		cfg_valid  <= 1'b1;
		window_len <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		len_setting = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic word_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return MOST_NEG;
			1:       return 32'sh7fff_ffff;
			2:       return word_t'($urandom_range(0, 16)) - 8;
			3:       return word_t'($urandom_range(0, 1)) - 1;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic int effective_len(input len_t v);
		if (v == 0)
			return 1;
		if (v > WINDOW_DEPTH)
			return WINDOW_DEPTH;
		return int'(v);
	endfunction

	// A well-formed sequence: first mark on the opening item, last on the end.
	task automatic send_sequence(input int n);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample(), i == 0, i == n - 1);
	endtask

	// Items with random marks, including runs with no first mark at all.
	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
	endtask

	// Samples before any first mark continue the empty sequence left by reset.
	task automatic test_no_first_mark();
		write_window_len(5'd3);
		send_sample(32'sd10, 1'b0, 1'b0);
		send_sample(-32'sd20, 1'b0, 1'b0);
		send_sample(32'sh7fff_ffff, 1'b0, 1'b0);
		send_sample(32'sd5, 1'b0, 1'b1);
	endtask

	// One-sample sequences pass through whatever the window length; a zero
	// length behaves as one.
	task automatic test_single_sample();
		write_window_len(5'd16);
		send_sample(MOST_NEG, 1'b1, 1'b1);
		write_window_len(5'd0);
		send_sample(-32'sd1, 1'b1, 1'b1);
		send_sample(32'sd42, 1'b1, 1'b0);
		send_sample(32'sd7, 1'b0, 1'b1);
	endtask

	// Sequences shorter than the window stay silent; a longer one walks the
	// extremes through the window.
	task automatic test_short_sequences();
		write_window_len(5'd4);
		send_sample(32'sd1, 1'b1, 1'b0);
		send_sample(32'sd2, 1'b0, 1'b1);
		send_sample(32'sd3, 1'b1, 1'b0);
		send_sample(32'sd4, 1'b0, 1'b0);
		send_sample(32'sd5, 1'b0, 1'b1);
		send_sample(MOST_NEG, 1'b1, 1'b0);
		send_sample(32'sh7fff_ffff, 1'b0, 1'b0);
		send_sample(-32'sd1, 1'b0, 1'b0);
		send_sample(32'sd0, 1'b0, 1'b0);
		send_sample(32'sd1, 1'b0, 1'b0);
		send_sample(MOST_NEG, 1'b0, 1'b1);
	endtask

	// A new length applies at once to the samples already held.
	task automatic test_len_change_mid_sequence();
		write_window_len(5'd2);
		send_sample(32'sd10, 1'b1, 1'b0);
		send_sample(32'sd20, 1'b0, 1'b0);
		write_window_len(5'd5);
		send_sample(-32'sd3, 1'b0, 1'b0);
		send_sample(-32'sd4, 1'b0, 1'b0);
		send_sample(-32'sd5, 1'b0, 1'b1);
	endtask

	// Random traffic in blocks, each under its own window length. Most items
	// form proper sequences; the rest are one-sample, short or noise.
	task automatic test_random_traffic(input int n_items, input int send_pct,
			input int recv_pct);
		int   sent;
		int   block_end;
		int   k;
		int   n;
		len_t v;
		sent          = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0:       v = 5'd0;
				1:       v = len_t'($urandom_range(WINDOW_DEPTH + 1, 31));
				2:       v = len_t'(WINDOW_DEPTH);
				3:       v = 5'd1;
				default: v = len_t'($urandom_range(1, WINDOW_DEPTH));
			endcase
			write_window_len(v);
			k         = effective_len(v);
			block_end = sent + $urandom_range(30, 90);
			while (sent < block_end && sent < n_items) begin
				case ($urandom_range(0, 9))
					0:       n = 1;
					1:       n = (k > 2) ? $urandom_range(2, k - 1) : 2;
					2: begin
						n = $urandom_range(1, 20);
						send_noise(n);
						sent += n;
						continue;
					end
					default: n = $urandom_range(k, 3 * k + 2);
				endcase
				send_sequence(n);
				sent += n;
			end
		end
	endtask

	initial begin
		len_setting = 5'd1;
		flush_window();
		// hold reset from time zero, then release it once and for good
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_first_mark();
		test_single_sample();
		test_short_sequences();
		test_len_change_mid_sequence();

		test_random_traffic(RANDOM_ITEMS, 10, 55);
		test_random_traffic(RANDOM_ITEMS, 55, 10);
		test_random_traffic(RANDOM_ITEMS, 0, 0);

		drain_results();
		if (mismatches == 0 && expected_maxima.size() == 0) begin
			$display("tb_sliding_window_max_core OK");
		end else begin
			$display("tb_sliding_window_max_core NOT OK");
		end
		$finish;
	end

endmodule

/* files.f */
sv/swm_pkg.sv
sv/swm_cell.sv
sv/swm_ctrl.sv
sv/sliding_window_max_core.sv
sv/swm_checker.sv
test/tb_sliding_window_max_core.sv
